// File: rtl/core/assert_macros.svh
// assertion macros used by base64_stream_decoder_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// File: rtl/core/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the symbol table of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	// default depth of the burst queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// reset value of the strict padding register
	localparam logic STRICT_RESET = 1'b1;

	// decoder modes
	localparam logic [1:0] MODE_DECODE = 2'd0;
	localparam logic [1:0] MODE_PADS   = 2'd1;
	localparam logic [1:0] MODE_OK     = 2'd2;
	localparam logic [1:0] MODE_BAD    = 2'd3;

	// character codes
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_PAD = 8'h3D;

	// symbol value that marks a character outside the alphabet
	localparam logic [6:0] SYM_NONE = 7'd64;

	// status codes
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	// result kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// results caused by one character, handed from front to back
	typedef struct packed {
		logic [7:0] data0;
		logic [7:0] data1;
		logic [7:0] data2;
		logic [1:0] nbytes;
		logic       has_status;
		logic       status;
	} burst_t;

	// standard alphabet lookup, SYM_NONE for anything else
	function automatic logic [6:0] sym_value(input logic [7:0] c);
		logic [6:0] v;
		v = SYM_NONE;
		if (c >= 8'h41 && c <= 8'h5A) begin
			v = 7'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			v = 7'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			v = 7'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			v = 7'd62;
		end else if (c == 8'h2F) begin
			v = 7'd63;
		end
		return v;
	endfunction

endpackage

// File: rtl/core/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Takes one character per cycle while accept is high, keeps the group and
// padding state and turns each character into a burst of zero to four results.
// ----------------------------------------------------------------------------
module b64d_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic            cfg_wr_data,
	input  logic            accept,
	input  logic [7:0]      in_char,
	input  logic            is_last,
	output logic            burst_push,
	output b64d_pkg::burst_t burst
);
	import b64d_pkg::*;

	logic        strict_q;
	logic [1:0]  mode_q, mode_n;
	logic [1:0]  phase_q, phase_n;
	logic [17:0] acc_q, acc_n;
	logic [1:0]  pads_q, pads_n;
	logic [6:0]  sym;
	logic        space;
	logic        pad_now;
	logic        flush_now;
	logic        do_flush;
	logic [23:0] full_grp;
	burst_t      br;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= STRICT_RESET;
		end else if (cfg_wr_en) begin
			strict_q <= cfg_wr_data;
		end
	end

	// character classification and next state
	always_comb begin
		sym       = sym_value(in_char);
		space     = (in_char >= CHAR_TAB) && (in_char <= CHAR_CR);
		full_grp  = {acc_q, sym[5:0]};
		mode_n    = mode_q;
		phase_n   = phase_q;
		acc_n     = acc_q;
		pads_n    = pads_q;
		pad_now   = 1'b0;
		flush_now = 1'b0;
		br        = '0;
		case (mode_q)
			MODE_DECODE: begin
				if (sym != SYM_NONE) begin
					if (phase_q == 2'd3) begin
						br.data0  = full_grp[23:16];
						br.data1  = full_grp[15:8];
						br.data2  = full_grp[7:0];
						br.nbytes = 2'd3;
						phase_n   = 2'd0;
						acc_n     = '0;
					end else begin
						acc_n   = {acc_q[11:0], sym[5:0]};
						phase_n = phase_q + 2'd1;
					end
				end else if (!space) begin
					if (phase_q == 2'd0) begin
						mode_n = MODE_OK;
					end else if (phase_q == 2'd1) begin
						mode_n = MODE_BAD;
					end else if (!strict_q) begin
						flush_now = 1'b1;
						mode_n    = MODE_OK;
					end else begin
						pads_n  = 2'(3'd4 - {1'b0, phase_q});
						mode_n  = MODE_PADS;
						pad_now = 1'b1;
					end
				end
			end
			MODE_PADS: begin
				pad_now = !space;
			end
			default: begin
			end
		endcase

		// padding character handling
		if (pad_now) begin
			if (in_char == CHAR_PAD) begin
				pads_n = pads_n - 2'd1;
				if (pads_n == 2'd0) begin
					flush_now = 1'b1;
					mode_n    = MODE_OK;
				end
			end else begin
				mode_n = MODE_BAD;
			end
		end

		// pending bytes of a partial group go out on a good stop or stream end
		do_flush = flush_now || (is_last && mode_n == MODE_DECODE && phase_n != 2'd1);
		if (do_flush) begin
			case (phase_n)
				2'd2: begin
					br.data0  = acc_n[11:4];
					br.nbytes = 2'd1;
				end
				2'd3: begin
					br.data0  = acc_n[17:10];
					br.data1  = acc_n[9:2];
					br.nbytes = 2'd2;
				end
				default: begin
				end
			endcase
			phase_n = 2'd0;
			acc_n   = '0;
		end

		// stream end closes with a status and clears the state
		if (is_last) begin
			br.has_status = 1'b1;
			if (mode_n == MODE_DECODE) begin
				br.status = (phase_n == 2'd1) ? STATUS_BAD : STATUS_OK;
			end else begin
				br.status = (mode_n == MODE_OK) ? STATUS_OK : STATUS_BAD;
			end
			mode_n  = MODE_DECODE;
			phase_n = 2'd0;
			acc_n   = '0;
			pads_n  = 2'd0;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_DECODE;
			phase_q <= 2'd0;
			acc_q   <= '0;
			pads_q  <= 2'd0;
		end else if (accept) begin
			mode_q  <= mode_n;
			phase_q <= phase_n;
			acc_q   <= acc_n;
			pads_q  <= pads_n;
		end
	end

	// only characters that cause results enter the queue
	assign burst_push = accept && (br.nbytes != 2'd0 || br.has_status);
	assign burst      = br;

endmodule

// File: rtl/core/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short first-in first-out queue of result bursts between front and back.
// ----------------------------------------------------------------------------
module b64d_queue #(
	parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  b64d_pkg::burst_t wr_data,
	output logic             full,
	input  logic             rd_en,
	output b64d_pkg::burst_t rd_data,
	output logic             empty
);
	import b64d_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
	localparam logic [PW-1:0] PTR_ONE = PW'(1);
	localparam logic [CW-1:0] CNT_ONE = CW'(1);

	burst_t          entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_wr;
	logic            do_rd;

	assign full  = (count_q == DEPTH_CNT);
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_ONE;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_ONE;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_ONE;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

endmodule

// File: rtl/core/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Walks the burst at the queue head and hands out its results one per
// transfer, the data bytes first and the status item last.
// ----------------------------------------------------------------------------
module b64d_back (
	input  logic             clk,
	input  logic             arst_n,
	input  b64d_pkg::burst_t head,
	input  logic             head_empty,
	input  logic             pop,
	output logic             head_pop,
	output logic [7:0]       out_byte,
	output logic             item_kind,
	output logic             status_code,
	output logic             last_of_run
);
	import b64d_pkg::*;

	logic [1:0] idx_q;
	logic       at_status;
	logic       is_final;
	logic       take;

	// position inside the head burst
	assign at_status = head.has_status && (idx_q == head.nbytes);
	assign is_final  = head.has_status ? (idx_q == head.nbytes)
	                                   : (idx_q == head.nbytes - 2'd1);
	assign take      = pop && !head_empty;
	assign head_pop  = take && is_final;

	// result fields
	always_comb begin
		out_byte    = 8'd0;
		item_kind   = KIND_DATA;
		status_code = STATUS_OK;
		if (at_status) begin
			item_kind   = KIND_STATUS;
			status_code = head.status;
		end else begin
			case (idx_q)
				2'd0:    out_byte = head.data0;
				2'd1:    out_byte = head.data1;
				2'd2:    out_byte = head.data2;
				default: out_byte = 8'd0;
			endcase
		end
		last_of_run = is_final;
	end

	// step through the burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (take) begin
			idx_q <= is_final ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// File: rtl/core/base64_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming base64 decoder, one character in per transfer, bytes and an
// end-of-stream status out in order.
// ----------------------------------------------------------------------------
// A character is taken in every cycle in which push is high and full is low;
// the front updates the group state in that same cycle and writes the results
// the character causes, if any (one to four), into a queue of QUEUE_DEPTH
// bursts as one entry. Results leave one per cycle while pop is high and
// empty is low: a completed group gives three results, a stream end up to
// four. full rises only when all QUEUE_DEPTH entries are waiting on the
// result side. strict_padding is written through cfg_wr_en and cfg_wr_data
// and resets to 1.
module base64_stream_decoder_core #(
	parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_char,
	input  logic       is_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       item_kind,
	output logic       status_code,
	output logic       last_of_run
);
	import b64d_pkg::*;
	`include "assert_macros.svh"

	logic   accept;
	logic   bq_push;
	logic   bq_pop;
	burst_t bq_wr;
	burst_t bq_head;

	assign accept = push && !full;

	// front: classify and decode
	b64d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.accept      (accept),
		.in_char     (in_char),
		.is_last     (is_last),
		.burst_push  (bq_push),
		.burst       (bq_wr)
	);

	// burst queue
	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (bq_push),
		.wr_data (bq_wr),
		.full    (full),
		.rd_en   (bq_pop),
		.rd_data (bq_head),
		.empty   (empty)
	);

	// back: serialize results
	b64d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (bq_head),
		.head_empty  (empty),
		.pop         (pop),
		.head_pop    (bq_pop),
		.out_byte    (out_byte),
		.item_kind   (item_kind),
		.status_code (status_code),
		.last_of_run (last_of_run)
	);

	// checks
	`ASSERT_NEVER(a_push_when_full, bq_push && full, "burst written into a full queue")
	`ASSERT_IMPLY(a_head_nonempty, !empty, bq_head.nbytes != 2'd0 || bq_head.has_status, "queued burst holds no result")
	`ASSERT_IMPLY(a_status_closes, !empty && item_kind == KIND_STATUS, last_of_run, "status item not last of its run")
	`ASSERT_IMPLY(a_data_no_status, !empty && item_kind == KIND_DATA, status_code == STATUS_OK, "data item carries a status")

endmodule
